[src/v3n_pkg.sv]
// ---------------------------------------------------------------------------
// v3n_pkg: shared types and constants for the vector normalizer
// Widths of the component, square, root and quotient datapaths.
// ---------------------------------------------------------------------------
package v3n_pkg;

  localparam int COMP_W     = 32;               // component width, Q16.16
  localparam int MAG_W      = COMP_W;           // magnitude fits in 32 bits unsigned
  localparam int SQ_W       = 2 * MAG_W - 1;    // square of at most 2^31, up to 2^62
  localparam int SUM_W      = 2 * MAG_W;        // sum of three squares
  localparam int ROOT_W     = MAG_W;            // floor root width
  localparam int ROOT_STEPS = ROOT_W;           // one root bit per stage
  localparam int SREM_W     = ROOT_W + 3;       // root remainder width
  localparam int UNIT_SHIFT = 30;
  localparam int Q_W        = UNIT_SHIFT + 1;   // quotient bits 30..0
  localparam int DIV_STEPS  = Q_W;              // one quotient bit per stage
  localparam int DREM_W     = ROOT_W + 1;       // divider remainder width
  localparam int NLANE      = 3;

  localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(1) << UNIT_SHIFT;

  // Per-vector data that travels beside the root pipeline
  typedef struct packed {
    logic [NLANE-1:0][MAG_W-1:0] mag;
    logic [NLANE-1:0]            neg;
  } side_t;

endpackage

[src/v3n_square.sv]
// ---------------------------------------------------------------------------
// v3n_square: one component lane, magnitude and square
// Splits a signed component into sign and magnitude, then squares it.
// ---------------------------------------------------------------------------
module v3n_square (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [v3n_pkg::COMP_W-1:0] comp,
  output logic        [v3n_pkg::MAG_W-1:0]  mag_r,
  output logic                              neg_r,
  output logic        [v3n_pkg::SQ_W-1:0]   sq_r
);

  logic [v3n_pkg::MAG_W-1:0] mag_nxt;
  logic [2*v3n_pkg::MAG_W-1:0] prod;

  assign mag_nxt = comp[v3n_pkg::COMP_W-1] ? (v3n_pkg::MAG_W'(0) - v3n_pkg::MAG_W'(comp))
                                           : v3n_pkg::MAG_W'(comp);
  assign prod = mag_nxt * mag_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      neg_r <= comp[v3n_pkg::COMP_W-1];
      sq_r  <= prod[v3n_pkg::SQ_W-1:0];
    end
  end

endmodule

[src/v3n_sqrt.sv]
// ---------------------------------------------------------------------------
// v3n_sqrt: pipelined floor square root
// Digit-by-digit root, one result bit per stage; side data rides along.
// ---------------------------------------------------------------------------
module v3n_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [v3n_pkg::SUM_W-1:0]    sum,
  input  v3n_pkg::side_t               side_in,
  output logic [v3n_pkg::ROOT_W-1:0]   root,
  output v3n_pkg::side_t               side_out
);

  localparam int N = v3n_pkg::ROOT_STEPS;

  logic [v3n_pkg::SUM_W-1:0]  rad_r  [N];
  logic [v3n_pkg::SREM_W-1:0] rem_r  [N];
  logic [v3n_pkg::ROOT_W-1:0] root_r [N];
  v3n_pkg::side_t             side_r [N];

  logic [v3n_pkg::SUM_W-1:0]  rad_nxt  [N];
  logic [v3n_pkg::SREM_W-1:0] rem_nxt  [N];
  logic [v3n_pkg::ROOT_W-1:0] root_nxt [N];

  always_comb begin
    logic [v3n_pkg::SUM_W-1:0]  rad_in;
    logic [v3n_pkg::SREM_W-1:0] rem_in;
    logic [v3n_pkg::ROOT_W-1:0] root_in;
    logic [v3n_pkg::SREM_W-1:0] cur;
    logic [v3n_pkg::SREM_W-1:0] trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rad_in  = sum;
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = rad_r[k-1];
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
      end
      cur   = {rem_in[v3n_pkg::SREM_W-3:0], rad_in[v3n_pkg::SUM_W-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      rad_nxt[k] = {rad_in[v3n_pkg::SUM_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_nxt[k]  = cur - trial;
        root_nxt[k] = {root_in[v3n_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cur;
        root_nxt[k] = {root_in[v3n_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 0; k < N; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
      for (int k = 1; k < N; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign root     = root_r[N-1];
  assign side_out = side_r[N-1];

endmodule

[src/v3n_div.sv]
// ---------------------------------------------------------------------------
// v3n_div: one divider lane
// Restoring division of (mag << 30) by the length, one quotient bit per stage;
// saturates, applies the sign and forces zero for a zero length.
// ---------------------------------------------------------------------------
module v3n_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [v3n_pkg::MAG_W-1:0]         mag,
  input  logic                              neg,
  input  logic [v3n_pkg::ROOT_W-1:0]        len,
  output logic signed [v3n_pkg::COMP_W-1:0] unit
);

  localparam int N = v3n_pkg::DIV_STEPS;

  logic [v3n_pkg::DREM_W-1:0] rem_r [N];
  logic [v3n_pkg::Q_W-1:0]    q_r   [N];
  logic [v3n_pkg::ROOT_W-1:0] len_r [N];
  logic                       neg_r [N];

  logic [v3n_pkg::DREM_W-1:0] rem_nxt [N];
  logic [v3n_pkg::Q_W-1:0]    q_nxt   [N];
  logic [v3n_pkg::Q_W-1:0]    q_sat;

  always_comb begin
    logic [v3n_pkg::DREM_W-1:0] rem_in;
    logic [v3n_pkg::Q_W-1:0]    q_in;
    logic [v3n_pkg::ROOT_W-1:0] d_in;
    logic [v3n_pkg::DREM_W-1:0] cur;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        // bits above quotient bit 30 give mag >> 1, always below a nonzero length
        rem_in = v3n_pkg::DREM_W'(mag >> 1);
        q_in   = '0;
        d_in   = len;
        cur    = {rem_in[v3n_pkg::DREM_W-2:0], mag[0]};
      end else begin
        rem_in = rem_r[k-1];
        q_in   = q_r[k-1];
        d_in   = len_r[k-1];
        cur    = {rem_in[v3n_pkg::DREM_W-2:0], 1'b0};
      end
      if (cur >= {1'b0, d_in}) begin
        rem_nxt[k] = cur - {1'b0, d_in};
        q_nxt[k]   = {q_in[v3n_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = cur;
        q_nxt[k]   = {q_in[v3n_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= len;
      neg_r[0] <= neg;
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
      for (int k = 1; k < N; k++) begin
        len_r[k] <= len_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign q_sat = (q_r[N-1] > v3n_pkg::UNIT_ONE) ? v3n_pkg::UNIT_ONE : q_r[N-1];

  always_comb begin
    if (len_r[N-1] == '0) begin
      unit = '0;
    end else if (neg_r[N-1]) begin
      unit = v3n_pkg::COMP_W'(0) - v3n_pkg::COMP_W'(q_sat);
    end else begin
      unit = v3n_pkg::COMP_W'(q_sat);
    end
  end

endmodule

[src/vector3_normalize.sv]
// ---------------------------------------------------------------------------
// vector3_normalize: 3D vector to unit vector, Q16.16 in, Q1.30 out
// Fully pipelined; one vector per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
// Takes one vector per clock and returns one unit vector per clock while the
// output is not back-pressured. The pipe holds one stage for magnitudes and
// squares (three multiplier lanes), one for the sum, 32 for the floor square
// root (one root bit per stage) and 31 for the three divider lanes (one
// quotient bit per stage), plus the output register. The whole pipe advances
// together: it moves whenever the output register is empty or its transfer
// completes, so a back-pressured output holds the pipe and in_ready drops. An
// all-zero vector returns the zero vector with zero_length set.
module vector3_normalize (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [v3n_pkg::COMP_W-1:0] in_vec_x,
  input  logic signed [v3n_pkg::COMP_W-1:0] in_vec_y,
  input  logic signed [v3n_pkg::COMP_W-1:0] in_vec_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [v3n_pkg::COMP_W-1:0] out_unit_x,
  output logic signed [v3n_pkg::COMP_W-1:0] out_unit_y,
  output logic signed [v3n_pkg::COMP_W-1:0] out_unit_z,
  output logic                              out_zero_length
);

  // square, sum, root stages, divide stages
  localparam int PIPE = 2 + v3n_pkg::ROOT_STEPS + v3n_pkg::DIV_STEPS;

  logic en;
  logic [PIPE-1:0] vld_r;
  logic            out_valid_r;

  logic signed [v3n_pkg::COMP_W-1:0] comp [v3n_pkg::NLANE];
  logic [v3n_pkg::MAG_W-1:0] mag_s  [v3n_pkg::NLANE];
  logic                      neg_s  [v3n_pkg::NLANE];
  logic [v3n_pkg::SQ_W-1:0]  sq_s   [v3n_pkg::NLANE];

  logic [v3n_pkg::SUM_W-1:0] sum_r;
  v3n_pkg::side_t            side_r;
  v3n_pkg::side_t            side_root;
  logic [v3n_pkg::ROOT_W-1:0] len;

  logic signed [v3n_pkg::COMP_W-1:0] unit [v3n_pkg::NLANE];
  logic signed [v3n_pkg::COMP_W-1:0] ux_r, uy_r, uz_r;
  logic                              zl_r;

  // Pipe moves when the output slot is free or is being taken this cycle
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign comp[0] = in_vec_x;
  assign comp[1] = in_vec_y;
  assign comp[2] = in_vec_z;

  // Magnitude and square lanes
  for (genvar g = 0; g < v3n_pkg::NLANE; g++) begin : g_sq
    v3n_square u_sq (
      .clk  (clk),
      .en   (en),
      .comp (comp[g]),
      .mag_r(mag_s[g]),
      .neg_r(neg_s[g]),
      .sq_r (sq_s[g])
    );
  end

  // Merge: full-width sum of squares, below 2^64 for any input
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= v3n_pkg::SUM_W'(sq_s[0]) + v3n_pkg::SUM_W'(sq_s[1])
             + v3n_pkg::SUM_W'(sq_s[2]);
      for (int i = 0; i < v3n_pkg::NLANE; i++) begin
        side_r.mag[i] <= mag_s[i];
        side_r.neg[i] <= neg_s[i];
      end
    end
  end

  v3n_sqrt u_sqrt (
    .clk     (clk),
    .en      (en),
    .sum     (sum_r),
    .side_in (side_r),
    .root    (len),
    .side_out(side_root)
  );

  // Divider lanes share the length
  for (genvar g = 0; g < v3n_pkg::NLANE; g++) begin : g_div
    v3n_div u_div (
      .clk (clk),
      .en  (en),
      .mag (side_root.mag[g]),
      .neg (side_root.neg[g]),
      .len (len),
      .unit(unit[g])
    );
  end

  // Zero-length flag: the length is zero only for the zero vector, so
  // every lane reads zero; delay a flag from the root output.
  logic [v3n_pkg::DIV_STEPS-1:0] zflag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      zflag_r <= {zflag_r[v3n_pkg::DIV_STEPS-2:0], (len == '0)};
    end
  end

  // Valid tracking and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE-2:0], in_valid};
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= unit[0];
      uy_r <= unit[1];
      uz_r <= unit[2];
      zl_r <= zflag_r[v3n_pkg::DIV_STEPS-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = ux_r;
  assign out_unit_y      = uy_r;
  assign out_unit_z      = uz_r;
  assign out_zero_length = zl_r;

  // A zero-length result carries the zero vector
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_unit_x == 0 && out_unit_y == 0 && out_unit_z == 0)
    else $error("zero length with nonzero unit vector");

  // Every component stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unit_x <= 32'sd1073741824 && out_unit_x >= -32'sd1073741824
               && out_unit_y <= 32'sd1073741824 && out_unit_y >= -32'sd1073741824
               && out_unit_z <= 32'sd1073741824 && out_unit_z >= -32'sd1073741824)
    else $error("unit component out of range");

  // A stalled result holds while the pipe is frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unit_x) && $stable(vld_r))
    else $error("pipe moved under a stalled output");

endmodule
